### rtl/core/event_trace_ring_buffer_assert.svh
// Assertion macros for the trace ring RTL.
// No dependencies; included by etrb_datapath, the module that carries assertions.
`ifndef EVENT_TRACE_RING_BUFFER_ASSERT_SVH
`define EVENT_TRACE_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define ETRB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define ETRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/etrb_pkg.sv
// Shared types and constants for the event trace ring.
// No dependencies; imported by etrb_ctrl, etrb_datapath and the top module.
package etrb_pkg;

   localparam int RING_DEPTH = 32;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int LIVE_W     = 7;
   localparam int CAP_W      = 7;
   localparam int MASK_W     = 8;
   localparam logic [MASK_W-1:0] CAT_ALL = 8'hFF;

   typedef enum logic [2:0] {
      KIND_RECORD   = 3'd0,
      KIND_START    = 3'd1,
      KIND_STOP     = 3'd2,
      KIND_FREEZE   = 3'd3,
      KIND_RESET    = 3'd4,
      KIND_SNAPSHOT = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SNAP_READ,
      ST_SNAP_LOAD,
      ST_SNAP_INFO
   } state_type;

   typedef struct packed {
      logic [31:0] sequence_num;
      logic [31:0] stamp;
      logic [15:0] thread;
      logic [15:0] event_code;
      logic [31:0] first_arg;
      logic [31:0] second_arg;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic record;
      logic start;
      logic stop;
      logic freeze;
      logic clear;
      logic snap_begin;
      logic read;
      logic load_rec;
      logic load_info;
   } ctrl_cmd_type;

   typedef struct packed {
      logic snap_empty;
      logic snap_last;
      logic out_free;
   } ctrl_status_type;

endpackage

### rtl/core/etrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module etrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/etrb_ctrl.sv
// Controller for the trace ring: decodes items and sequences snapshot reads.
// Depends on etrb_pkg; drives commands into etrb_datapath.
module etrb_ctrl
   import etrb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [2:0]      req_kind,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_SNAPSHOT)) begin
               state_in = ST_SNAP_READ;
            end
         end
         ST_SNAP_READ: begin
            state_in = status.snap_empty ? ST_SNAP_INFO : ST_SNAP_LOAD;
         end
         ST_SNAP_LOAD: begin
            if (status.out_free) begin
               state_in = status.snap_last ? ST_IDLE : ST_SNAP_READ;
            end
         end
         ST_SNAP_INFO: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      if (accept) begin
         case (req_kind)
            KIND_RECORD:   cmd.record     = 1'b1;
            KIND_START:    cmd.start      = 1'b1;
            KIND_STOP:     cmd.stop       = 1'b1;
            KIND_FREEZE:   cmd.freeze     = 1'b1;
            KIND_RESET:    cmd.clear      = 1'b1;
            KIND_SNAPSHOT: cmd.snap_begin = 1'b1;
            default:       cmd            = '0;
         endcase
      end
      cmd.read      = (state_ff == ST_SNAP_READ) && !status.snap_empty;
      cmd.load_rec  = (state_ff == ST_SNAP_LOAD) && status.out_free;
      cmd.load_info = (state_ff == ST_SNAP_INFO) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/etrb_datapath.sv
// Datapath for the trace ring: flags, counters, slot RAM, snapshot walker
// and the result register. Depends on etrb_pkg, etrb_ram and the assert macros.
`include "event_trace_ring_buffer_assert.svh"

module etrb_datapath
   import etrb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [MASK_W-1:0]  csr_write_data,
   input  logic [15:0]        req_event_code,
   input  logic [31:0]        req_first_arg,
   input  logic [31:0]        req_second_arg,
   input  logic [31:0]        req_stamp,
   input  logic [15:0]        req_thread_ident,
   input  logic [CAP_W-1:0]   req_capacity,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_has_record,
   output logic [31:0]        rsp_rec_sequence,
   output logic [31:0]        rsp_rec_stamp,
   output logic [15:0]        rsp_rec_thread,
   output logic [15:0]        rsp_rec_event,
   output logic [31:0]        rsp_rec_first_arg,
   output logic [31:0]        rsp_rec_second_arg,
   output logic               rsp_last_of_run,
   output logic [31:0]        rsp_overwrite_total,
   output logic [31:0]        rsp_latest_seq,
   output logic [LIVE_W-1:0]  rsp_live_count
);

   localparam int SUM_W = CNT_W + 1;

   // control state
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              running_ff, running_in;
   logic              frozen_ff, frozen_in;
   logic [IDX_W-1:0]  wr_slot_ff, wr_slot_in;
   logic [31:0]       next_seq_ff, next_seq_in;
   logic [31:0]       ovw_ff, ovw_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic [31:0]       newest_ff, newest_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic              out_valid_ff, out_valid_in;

   // result payload
   slot_type          out_slot_ff, out_slot_in;
   logic              out_has_ff, out_has_in;
   logic              out_last_ff, out_last_in;
   logic [31:0]       out_ovw_ff, out_ovw_in;
   logic [31:0]       out_newest_ff, out_newest_in;
   logic [CNT_W-1:0]  out_live_ff, out_live_in;

   logic              keep;
   logic              ring_full;
   logic [31:0]       seq_inc;
   logic [CAP_W-1:0]  live_cap;
   logic [CAP_W-1:0]  wanted_wide;
   logic [CNT_W-1:0]  wanted;
   logic [SUM_W-1:0]  wr_ext;
   logic [SUM_W-1:0]  wanted_ext;
   logic [SUM_W-1:0]  start_sum;
   logic              taken;
   slot_type          wr_slot_data;
   logic [SLOT_W-1:0] rd_data;

   assign keep      = running_ff && !frozen_ff && ((mask_ff & req_event_code[15:8]) != '0);
   assign ring_full = (live_ff == CNT_W'(RING_DEPTH));
   assign seq_inc   = next_seq_ff + 32'd1;

   // newest records only: start (wanted) slots behind the write position
   assign live_cap    = CAP_W'(live_ff);
   assign wanted_wide = (req_capacity < live_cap) ? req_capacity : live_cap;
   assign wanted      = wanted_wide[CNT_W-1:0];
   assign wr_ext      = SUM_W'(wr_slot_ff);
   assign wanted_ext  = SUM_W'(wanted);
   assign start_sum   = (wr_ext >= wanted_ext) ? (wr_ext - wanted_ext)
                                               : (wr_ext + SUM_W'(RING_DEPTH) - wanted_ext);

   assign taken = out_valid_ff && !rsp_stall;

   assign status.snap_empty = (remain_ff == '0);
   assign status.snap_last  = (remain_ff == CNT_W'(1));
   assign status.out_free   = !out_valid_ff || !rsp_stall;

   always_comb begin
      wr_slot_data.sequence_num = next_seq_ff;
      wr_slot_data.stamp        = req_stamp;
      wr_slot_data.thread       = req_thread_ident;
      wr_slot_data.event_code   = req_event_code;
      wr_slot_data.first_arg    = req_first_arg;
      wr_slot_data.second_arg   = req_second_arg;
   end

   etrb_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (RING_DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (cmd.record && keep),
      .waddr (wr_slot_ff),
      .wdata (wr_slot_data),
      .re    (cmd.read),
      .raddr (rd_idx_ff),
      .rdata (rd_data)
   );

   always_comb begin
      mask_in     = csr_write_enable ? csr_write_data : mask_ff;
      running_in  = running_ff;
      frozen_in   = frozen_ff;
      wr_slot_in  = wr_slot_ff;
      next_seq_in = next_seq_ff;
      ovw_in      = ovw_ff;
      live_in     = live_ff;
      newest_in   = newest_ff;
      rd_idx_in   = rd_idx_ff;
      remain_in   = remain_ff;

      if (cmd.record && keep) begin
         next_seq_in = (seq_inc == '0) ? 32'd1 : seq_inc;
         newest_in   = next_seq_ff;
         wr_slot_in  = (wr_slot_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_slot_ff + 1'b1;
         if (ring_full) begin
            ovw_in = ovw_ff + 32'd1;
         end else begin
            live_in = live_ff + 1'b1;
         end
      end
      if (cmd.start && !frozen_ff) begin
         running_in = 1'b1;
      end
      if (cmd.stop) begin
         running_in = 1'b0;
      end
      if (cmd.freeze) begin
         running_in = 1'b0;
         frozen_in  = 1'b1;
      end
      if (cmd.clear) begin
         running_in  = 1'b0;
         frozen_in   = 1'b0;
         wr_slot_in  = '0;
         next_seq_in = 32'd1;
         ovw_in      = '0;
         live_in     = '0;
         newest_in   = '0;
      end
      if (cmd.snap_begin) begin
         rd_idx_in = start_sum[IDX_W-1:0];
         remain_in = wanted;
      end
      // advance the walker as each record is handed to the result register
      if (cmd.load_rec) begin
         rd_idx_in = (rd_idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
         remain_in = remain_ff - 1'b1;
      end
   end

   always_comb begin
      out_slot_in   = out_slot_ff;
      out_has_in    = out_has_ff;
      out_last_in   = out_last_ff;
      out_ovw_in    = out_ovw_ff;
      out_newest_in = out_newest_ff;
      out_live_in   = out_live_ff;
      out_valid_in  = taken ? 1'b0 : out_valid_ff;

      if (cmd.load_rec || cmd.load_info) begin
         out_valid_in  = 1'b1;
         out_ovw_in    = ovw_ff;
         out_newest_in = newest_ff;
         out_live_in   = live_ff;
      end
      if (cmd.load_rec) begin
         out_slot_in = slot_type'(rd_data);
         out_has_in  = 1'b1;
         out_last_in = status.snap_last;
      end
      if (cmd.load_info) begin
         out_slot_in = '0;
         out_has_in  = 1'b0;
         out_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= CAT_ALL;
         running_ff   <= 1'b1;
         frozen_ff    <= 1'b0;
         wr_slot_ff   <= '0;
         next_seq_ff  <= 32'd1;
         ovw_ff       <= '0;
         live_ff      <= '0;
         newest_ff    <= '0;
         rd_idx_ff    <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         running_ff   <= running_in;
         frozen_ff    <= frozen_in;
         wr_slot_ff   <= wr_slot_in;
         next_seq_ff  <= next_seq_in;
         ovw_ff       <= ovw_in;
         live_ff      <= live_in;
         newest_ff    <= newest_in;
         rd_idx_ff    <= rd_idx_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_slot_ff   <= out_slot_in;
      out_has_ff    <= out_has_in;
      out_last_ff   <= out_last_in;
      out_ovw_ff    <= out_ovw_in;
      out_newest_ff <= out_newest_in;
      out_live_ff   <= out_live_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_has_record      = out_has_ff;
   assign rsp_rec_sequence    = out_slot_ff.sequence_num;
   assign rsp_rec_stamp       = out_slot_ff.stamp;
   assign rsp_rec_thread      = out_slot_ff.thread;
   assign rsp_rec_event       = out_slot_ff.event_code;
   assign rsp_rec_first_arg   = out_slot_ff.first_arg;
   assign rsp_rec_second_arg  = out_slot_ff.second_arg;
   assign rsp_last_of_run     = out_last_ff;
   assign rsp_overwrite_total = out_ovw_ff;
   assign rsp_latest_seq      = out_newest_ff;
   assign rsp_live_count      = LIVE_W'(out_live_ff);

   `ETRB_ASSERT_NOW(a_live_bound, clock, reset, 1'b1, live_ff <= CNT_W'(RING_DEPTH),
                    "live count above ring depth")
   `ETRB_ASSERT_NOW(a_seq_nonzero, clock, reset, 1'b1, next_seq_ff != '0,
                    "next sequence is zero")
   `ETRB_ASSERT_NOW(a_newest_empty, clock, reset, 1'b1,
                    (live_ff == '0) == (newest_ff == '0),
                    "newest sequence disagrees with live count")
   `ETRB_ASSERT_NOW(a_info_last, clock, reset, out_valid_ff && !out_has_ff, out_last_ff,
                    "info-only result not marked last")
   `ETRB_ASSERT_NEXT(a_walk_bound, clock, reset, cmd.snap_begin, remain_ff <= live_ff,
                     "snapshot wants more than live records")

endmodule

### rtl/core/event_trace_ring_buffer.sv
// Event trace ring: captures filtered event records and returns snapshots.
// Request channel (req_*): one transaction per item; kind selects record,
// start, stop, freeze, reset or snapshot. Result channel (rsp_*): snapshot
// output only, oldest kept record first, last_of_run on the final result.
// csr_write_enable/csr_write_data load the 8-bit category mask at once.
// Non-snapshot items do not stall the request channel and give no result.
// A snapshot sets up its walk at the accepting edge, then for each record
// reads one slot from the RAM (ST_SNAP_READ) and loads it into the result
// register (ST_SNAP_LOAD); req_stall stays high for the whole walk. With no
// record to return it gives a single info-only result from ST_SNAP_INFO.
// The result register is single entry: while the receiver stalls the walk
// holds on the next record, and no new item is taken until the last result
// of the snapshot is loaded. After reset the ring is empty, tracing runs,
// nothing is frozen and the mask enables every category.
// Depends on etrb_pkg, etrb_ctrl and etrb_datapath.
module event_trace_ring_buffer
   import etrb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [MASK_W-1:0]  csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic [15:0]        req_event_code,
   input  logic [31:0]        req_first_arg,
   input  logic [31:0]        req_second_arg,
   input  logic [31:0]        req_stamp,
   input  logic [15:0]        req_thread_ident,
   input  logic [CAP_W-1:0]   req_capacity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_has_record,
   output logic [31:0]        rsp_rec_sequence,
   output logic [31:0]        rsp_rec_stamp,
   output logic [15:0]        rsp_rec_thread,
   output logic [15:0]        rsp_rec_event,
   output logic [31:0]        rsp_rec_first_arg,
   output logic [31:0]        rsp_rec_second_arg,
   output logic               rsp_last_of_run,
   output logic [31:0]        rsp_overwrite_total,
   output logic [31:0]        rsp_latest_seq,
   output logic [LIVE_W-1:0]  rsp_live_count
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   etrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   etrb_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_event_code      (req_event_code),
      .req_first_arg       (req_first_arg),
      .req_second_arg      (req_second_arg),
      .req_stamp           (req_stamp),
      .req_thread_ident    (req_thread_ident),
      .req_capacity        (req_capacity),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_has_record      (rsp_has_record),
      .rsp_rec_sequence    (rsp_rec_sequence),
      .rsp_rec_stamp       (rsp_rec_stamp),
      .rsp_rec_thread      (rsp_rec_thread),
      .rsp_rec_event       (rsp_rec_event),
      .rsp_rec_first_arg   (rsp_rec_first_arg),
      .rsp_rec_second_arg  (rsp_rec_second_arg),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_overwrite_total (rsp_overwrite_total),
      .rsp_latest_seq      (rsp_latest_seq),
      .rsp_live_count      (rsp_live_count)
   );

endmodule
